/* design/mcsr_pkg.sv */
// mcsr_pkg: shared types and constants for the mesh adjacency csr builder
// holds action codes, controller states and the command/status structs
// no dependencies
`default_nettype none

package mcsr_pkg;

  // default sizes of the adjacency storage
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_DEGREE_DEF   = 16;

  // field widths fixed by the interface
  localparam int NP_W  = 11;
  localparam int IDX_W = 10;
  localparam int OFF_W = 15;

  // action codes of a request
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_EMIT  = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_CHK,
    S_DEG_RD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_NEXT,
    S_EMIT_DEG,
    S_EMIT_ROW,
    S_EMIT_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clr_start;
    logic clr_step;
    logic ins_first;
    logic ins_next;
    logic deg_rd_ins;
    logic scan_rd;
    logic scan_inc;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic place;
    logic set_ovf;
    logic emit_deg_rd;
    logic emit_end;
    logic emit_empty;
    logic emit_first_rd;
    logic emit_word;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tri_ok;
    logic clr_last;
    logic i_eq_n;
    logic nb_lt_x;
    logic nb_eq_x;
    logic deg_full;
    logic k_eq_i;
    logic j_last;
    logic cursor_end;
    logic deg_zero;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

/* design/mcsr_ctrl.sv */
// mcsr_ctrl: sequencing state machine of the adjacency builder
// depends on mcsr_pkg for states, action codes and command/status structs
`default_nettype none

module mcsr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         action,
  input  wire mcsr_pkg::status_t  sts,
  output mcsr_pkg::cmd_t          cmd,
  output logic                    busy
);

  mcsr_pkg::state_t state, state_next;

  // state register, reset starts the degree clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcsr_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mcsr_pkg::S_CLEAR: begin
        if (sts.clr_last) state_next = mcsr_pkg::S_IDLE;
      end
      mcsr_pkg::S_IDLE: begin
        if (start) begin
          if (action == mcsr_pkg::ACT_CLEAR) begin
            state_next = mcsr_pkg::S_CLEAR;
          end else if (action == mcsr_pkg::ACT_ADD) begin
            state_next = mcsr_pkg::S_ADD_CHK;
          end else if (action == mcsr_pkg::ACT_EMIT) begin
            state_next = mcsr_pkg::S_EMIT_DEG;
          end
        end
      end
      mcsr_pkg::S_ADD_CHK: begin
        state_next = sts.tri_ok ? mcsr_pkg::S_DEG_RD : mcsr_pkg::S_IDLE;
      end
      mcsr_pkg::S_DEG_RD: state_next = mcsr_pkg::S_SCAN_RD;
      mcsr_pkg::S_SCAN_RD: begin
        state_next = sts.i_eq_n ? mcsr_pkg::S_DECIDE : mcsr_pkg::S_SCAN_CMP;
      end
      mcsr_pkg::S_SCAN_CMP: begin
        priority if (sts.nb_lt_x) state_next = mcsr_pkg::S_SCAN_RD;
        else if (sts.nb_eq_x)     state_next = mcsr_pkg::S_NEXT;
        else                      state_next = mcsr_pkg::S_DECIDE;
      end
      mcsr_pkg::S_DECIDE: begin
        state_next = sts.deg_full ? mcsr_pkg::S_NEXT : mcsr_pkg::S_SHIFT_RD;
      end
      mcsr_pkg::S_SHIFT_RD: begin
        state_next = sts.k_eq_i ? mcsr_pkg::S_NEXT : mcsr_pkg::S_SHIFT_WR;
      end
      mcsr_pkg::S_SHIFT_WR: state_next = mcsr_pkg::S_SHIFT_RD;
      mcsr_pkg::S_NEXT: begin
        state_next = sts.j_last ? mcsr_pkg::S_IDLE : mcsr_pkg::S_DEG_RD;
      end
      mcsr_pkg::S_EMIT_DEG: begin
        state_next = sts.cursor_end ? mcsr_pkg::S_IDLE : mcsr_pkg::S_EMIT_ROW;
      end
      mcsr_pkg::S_EMIT_ROW: begin
        state_next = sts.deg_zero ? mcsr_pkg::S_IDLE : mcsr_pkg::S_EMIT_OUT;
      end
      mcsr_pkg::S_EMIT_OUT: begin
        if (sts.emit_last) state_next = mcsr_pkg::S_IDLE;
      end
      default: state_next = mcsr_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd  = '0;
    busy = (state != mcsr_pkg::S_IDLE);
    unique case (state)
      mcsr_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      mcsr_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch     = 1'b1;
          cmd.clr_start = (action == mcsr_pkg::ACT_CLEAR);
        end
      end
      mcsr_pkg::S_ADD_CHK: cmd.ins_first = sts.tri_ok;
      mcsr_pkg::S_DEG_RD:  cmd.deg_rd_ins = 1'b1;
      mcsr_pkg::S_SCAN_RD: cmd.scan_rd = !sts.i_eq_n;
      mcsr_pkg::S_SCAN_CMP: cmd.scan_inc = sts.nb_lt_x;
      mcsr_pkg::S_DECIDE: begin
        cmd.set_ovf    = sts.deg_full;
        cmd.shift_init = !sts.deg_full;
      end
      mcsr_pkg::S_SHIFT_RD: begin
        cmd.place    = sts.k_eq_i;
        cmd.shift_rd = !sts.k_eq_i;
      end
      mcsr_pkg::S_SHIFT_WR: cmd.shift_wr = 1'b1;
      mcsr_pkg::S_NEXT: cmd.ins_next = !sts.j_last;
      mcsr_pkg::S_EMIT_DEG: begin
        cmd.emit_end    = sts.cursor_end;
        cmd.emit_deg_rd = !sts.cursor_end;
      end
      mcsr_pkg::S_EMIT_ROW: begin
        cmd.emit_empty    = sts.deg_zero;
        cmd.emit_first_rd = !sts.deg_zero;
      end
      mcsr_pkg::S_EMIT_OUT: cmd.emit_word = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/mcsr_datapath.sv */
// mcsr_datapath: degree and neighbor memories, counters and result registers
// depends on mcsr_pkg; driven by mcsr_ctrl through cmd_t, reports via status_t
`default_nettype none

module mcsr_datapath #(
  parameter int MAX_VERTICES = mcsr_pkg::MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = mcsr_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mcsr_pkg::cmd_t              cmd,
  output mcsr_pkg::status_t                sts,
  input  wire logic                        cfg_we,
  input  wire logic [mcsr_pkg::NP_W-1:0]   cfg_wdata,
  input  wire logic [mcsr_pkg::IDX_W-1:0]  vertex_a,
  input  wire logic [mcsr_pkg::IDX_W-1:0]  vertex_b,
  input  wire logic [mcsr_pkg::IDX_W-1:0]  vertex_c,
  output logic                             done,
  output logic [mcsr_pkg::NP_W-1:0]        row_vertex,
  output logic [mcsr_pkg::OFF_W-1:0]       row_offset,
  output logic [mcsr_pkg::IDX_W-1:0]       neighbor_index,
  output logic                             neighbor_valid,
  output logic                             row_last,
  output logic                             end_of_table,
  output logic                             overflow_seen
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE);
  localparam int CW = $clog2(MAX_DEGREE + 1);
  localparam int AW = VW + DW;
  localparam int NB_DEPTH = MAX_VERTICES * (2 ** DW);
  localparam int LIM_CAP = (MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES;

  // memories
  logic [CW-1:0]                deg_mem [MAX_VERTICES];
  logic [mcsr_pkg::IDX_W-1:0]   nb_mem  [NB_DEPTH];

  logic [mcsr_pkg::NP_W-1:0]    num_points;
  logic [mcsr_pkg::IDX_W-1:0]   va, vb, vc;
  logic [2:0]                   j;
  logic [CW-1:0]                i, k;
  logic [VW-1:0]                clr_addr;
  logic [mcsr_pkg::NP_W-1:0]    cursor;
  logic [mcsr_pkg::OFF_W-1:0]   offset;
  logic                         overflow;
  logic [CW-1:0]                deg_q;
  logic [mcsr_pkg::IDX_W-1:0]   nb_q;

  logic [mcsr_pkg::NP_W-1:0]    lim;
  logic [mcsr_pkg::IDX_W-1:0]   v, x;
  logic [VW-1:0]                v_addr, cur_addr;
  logic [AW-1:0]                nb_raddr;
  logic                         nb_re;
  logic                         advance;

  // effective vertex count
  assign lim = (num_points > mcsr_pkg::NP_W'(LIM_CAP)) ? mcsr_pkg::NP_W'(LIM_CAP)
                                                       : num_points;

  // vertex and partner of the current insert step
  always_comb begin
    unique case (j)
      3'd0:    begin v = va; x = vb; end
      3'd1:    begin v = va; x = vc; end
      3'd2:    begin v = vb; x = va; end
      3'd3:    begin v = vb; x = vc; end
      3'd4:    begin v = vc; x = va; end
      default: begin v = vc; x = vb; end
    endcase
  end

  assign v_addr   = VW'(v);
  assign cur_addr = VW'(cursor);

  // neighbor read address
  always_comb begin
    nb_re    = cmd.scan_rd | cmd.shift_rd | cmd.emit_first_rd | cmd.emit_word;
    nb_raddr = {cur_addr, DW'(k + CW'(1))};
    priority if (cmd.scan_rd)  nb_raddr = {v_addr, DW'(i)};
    else if (cmd.shift_rd)     nb_raddr = {v_addr, DW'(k - CW'(1))};
    else if (cmd.emit_first_rd) nb_raddr = {cur_addr, DW'(0)};
  end

  // degree memory: clearing sweep, insert update, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      deg_mem[clr_addr] <= '0;
    end else if (cmd.place) begin
      deg_mem[v_addr] <= deg_q + CW'(1);
    end
    if (cmd.deg_rd_ins) begin
      deg_q <= deg_mem[v_addr];
    end else if (cmd.emit_deg_rd) begin
      deg_q <= deg_mem[cur_addr];
    end
  end

  // neighbor memory: shift and place writes, registered read
  always_ff @(posedge clk) begin
    if (cmd.shift_wr) begin
      nb_mem[{v_addr, DW'(k)}] <= nb_q;
    end else if (cmd.place) begin
      nb_mem[{v_addr, DW'(i)}] <= x;
    end
    if (nb_re) begin
      nb_q <= nb_mem[nb_raddr];
    end
  end

  // latched corners and step counters
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      va <= vertex_a;
      vb <= vertex_b;
      vc <= vertex_c;
    end
    if (cmd.ins_first) j <= 3'd0;
    else if (cmd.ins_next) j <= j + 3'd1;
    if (cmd.deg_rd_ins) i <= '0;
    else if (cmd.scan_inc) i <= i + CW'(1);
    if (cmd.shift_init) k <= deg_q;
    else if (cmd.shift_wr) k <= k - CW'(1);
    else if (cmd.emit_deg_rd) k <= '0;
    else if (cmd.emit_word) k <= k + CW'(1);
  end

  assign advance = cmd.emit_empty | (cmd.emit_word & sts.emit_last);

  // control registers: config, clear sweep, cursor, offset, overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= '0;
      clr_addr   <= '0;
      cursor     <= '0;
      offset     <= '0;
      overflow   <= 1'b0;
    end else begin
      if (cfg_we) num_points <= cfg_wdata;
      if (cmd.clr_start) clr_addr <= '0;
      else if (cmd.clr_step) clr_addr <= clr_addr + VW'(1);
      if (cmd.clr_start) begin
        cursor <= '0;
        offset <= '0;
      end else if (advance) begin
        cursor <= cursor + mcsr_pkg::NP_W'(1);
        offset <= offset + mcsr_pkg::OFF_W'(deg_q);
      end
      if (cmd.set_ovf) overflow <= 1'b1;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_end | cmd.emit_empty | cmd.emit_word;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_end | cmd.emit_empty | cmd.emit_word) begin
      row_vertex     <= cmd.emit_end ? lim : cursor;
      row_offset     <= offset;
      neighbor_index <= cmd.emit_word ? nb_q : '0;
      neighbor_valid <= cmd.emit_word;
      row_last       <= cmd.emit_word ? sts.emit_last : 1'b1;
      end_of_table   <= cmd.emit_end;
    end
  end

  assign overflow_seen = overflow;

  // status toward the controller
  always_comb begin
    sts.tri_ok     = ({1'b0, va} < lim) && ({1'b0, vb} < lim) && ({1'b0, vc} < lim);
    sts.clr_last   = (clr_addr == VW'(MAX_VERTICES - 1));
    sts.i_eq_n     = (i == deg_q);
    sts.nb_lt_x    = (nb_q < x);
    sts.nb_eq_x    = (nb_q == x);
    sts.deg_full   = (deg_q == CW'(MAX_DEGREE));
    sts.k_eq_i     = (k == i);
    sts.j_last     = (j == 3'd5);
    sts.cursor_end = (cursor >= lim);
    sts.deg_zero   = (deg_q == '0);
    sts.emit_last  = ((k + CW'(1)) == deg_q);
  end

endmodule

`default_nettype wire

/* design/mesh_adjacency_csr_builder_top.sv */
// mesh_adjacency_csr_builder_top: top level of the adjacency csr builder
// depends on mcsr_pkg, mcsr_ctrl and mcsr_datapath
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  request   | start & !busy         | action, vertex_a, vertex_b, vertex_c
//  config    | cfg_we                | cfg_wdata (num_points)
//  result    | done, one cycle each  | row_vertex, row_offset, neighbor_index,
//            |                       | neighbor_valid, row_last, end_of_table,
//            |                       | overflow_seen
//
// an add first range checks the three corners, then, if all are in range, runs six
// sorted inserts; an insert scans the set for its place, shifts larger neighbors up
// and places the new one, and stops early on a duplicate or a full set
// an emit streams the row of the cursor vertex, or the end entry once the cursor
// reaches the vertex count; results follow one per cycle, registered from the command
// reset and clear both sweep all MAX_VERTICES degree entries to zero with busy high
// the receiver cannot stall: each result is shown for one cycle with done
`default_nettype none

module mesh_adjacency_csr_builder_top #(
  parameter int MAX_VERTICES = mcsr_pkg::MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = mcsr_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  action,
  input  wire logic [mcsr_pkg::IDX_W-1:0]  vertex_a,
  input  wire logic [mcsr_pkg::IDX_W-1:0]  vertex_b,
  input  wire logic [mcsr_pkg::IDX_W-1:0]  vertex_c,
  input  wire logic                        cfg_we,
  input  wire logic [mcsr_pkg::NP_W-1:0]   cfg_wdata,
  output logic                             done,
  output logic [mcsr_pkg::NP_W-1:0]        row_vertex,
  output logic [mcsr_pkg::OFF_W-1:0]       row_offset,
  output logic [mcsr_pkg::IDX_W-1:0]       neighbor_index,
  output logic                             neighbor_valid,
  output logic                             row_last,
  output logic                             end_of_table,
  output logic                             overflow_seen
);

  mcsr_pkg::cmd_t    cmd;
  mcsr_pkg::status_t sts;

  // sequencer
  mcsr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // storage and arithmetic
  mcsr_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .vertex_a       (vertex_a),
    .vertex_b       (vertex_b),
    .vertex_c       (vertex_c),
    .done           (done),
    .row_vertex     (row_vertex),
    .row_offset     (row_offset),
    .neighbor_index (neighbor_index),
    .neighbor_valid (neighbor_valid),
    .row_last       (row_last),
    .end_of_table   (end_of_table),
    .overflow_seen  (overflow_seen)
  );

endmodule

`default_nettype wire

/* design/mcsr_checker.sv */
// mcsr_checker: port level assertions for the adjacency csr builder
// depends on mcsr_pkg; bound to mesh_adjacency_csr_builder_top
`default_nettype none

module mcsr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  action,
  input wire logic        done,
  input wire logic [9:0]  neighbor_index,
  input wire logic        neighbor_valid,
  input wire logic        row_last,
  input wire logic        end_of_table
);

  // results only come out of a running request
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a running request");

  // end entry is a closing, empty result
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    (done && end_of_table) |-> (row_last && !neighbor_valid))
    else $error("end entry malformed");

  // empty results carry a zero neighbor
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !neighbor_valid) |-> (neighbor_index == 10'd0))
    else $error("empty result with nonzero neighbor");

  // a row streams without gaps
  a_row_stream: assert property (@(posedge clk) disable iff (rst)
    (done && !row_last) |=> done) else $error("gap inside a row");

  // a clear request starts the clearing sweep
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == mcsr_pkg::ACT_CLEAR) |=> busy)
    else $error("clear did not start sweep");

endmodule

bind mesh_adjacency_csr_builder_top mcsr_checker u_mcsr_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .action         (action),
  .done           (done),
  .neighbor_index (neighbor_index),
  .neighbor_valid (neighbor_valid),
  .row_last       (row_last),
  .end_of_table   (end_of_table)
);

`default_nettype wire

/* sim/mesh_adjacency_csr_builder_top_tb.sv */
// mesh_adjacency_csr_builder_top_tb: self-checking testbench for the adjacency csr builder
// drives clear, add and emit requests, predicts each csr result (or takes a literal one) and checks it field by field
// depends on mcsr_pkg and mesh_adjacency_csr_builder_top
`default_nettype none

module mesh_adjacency_csr_builder_top_tb;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int NV    = mcsr_pkg::MAX_VERTICES_DEF;
  localparam int ND    = mcsr_pkg::MAX_DEGREE_DEF;
  localparam int NP_W  = mcsr_pkg::NP_W;
  localparam int IDX_W = mcsr_pkg::IDX_W;
  localparam int OFF_W = mcsr_pkg::OFF_W;

  // one emitted csr word
  typedef struct {
    logic [NP_W-1:0]  vtx;
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] nb;
    logic             nb_ok;
    logic             last;
    logic             eot;
    logic             ovf;
  } csr_word_t;

  // directed row: optional config write first, optional literal first result
  typedef struct {
    bit               set_np;
    logic [NP_W-1:0]  np;
    logic [1:0]       act;
    logic [IDX_W-1:0] a, b, c;
    bit               lit;
    csr_word_t        w;
  } vec_t;

  logic clk, rst, start, busy, cfg_we, done;
  logic [1:0] action;
  logic [IDX_W-1:0] vertex_a, vertex_b, vertex_c;
  logic [NP_W-1:0] cfg_wdata;
  logic [NP_W-1:0] row_vertex;
  logic [OFF_W-1:0] row_offset;
  logic [IDX_W-1:0] neighbor_index;
  logic neighbor_valid, row_last, end_of_table, overflow_seen;

  mesh_adjacency_csr_builder_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
    .row_vertex(row_vertex), .row_offset(row_offset), .neighbor_index(neighbor_index),
    .neighbor_valid(neighbor_valid), .row_last(row_last), .end_of_table(end_of_table),
    .overflow_seen(overflow_seen)
  );

  // shadow copy of the adjacency state
  logic [4:0]       deg_sh [NV];
  logic [IDX_W-1:0] nbr_sh [NV][ND];
  logic [NP_W-1:0]  np_sh;
  logic [NP_W-1:0]  cursor_sh;
  logic [OFF_W-1:0] offset_sh;
  logic             ovf_sh;

  csr_word_t pending_words[$];
  int err_count = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic field_chk(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // check each strobed result against the oldest expectation
  always @(posedge clk) begin
    csr_word_t e;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = pending_words.pop_front();
        field_chk("row_vertex", row_vertex, e.vtx);
        field_chk("row_offset", row_offset, e.off);
        field_chk("neighbor_index", neighbor_index, e.nb);
        field_chk("neighbor_valid", neighbor_valid, e.nb_ok);
        field_chk("row_last", row_last, e.last);
        field_chk("end_of_table", end_of_table, e.eot);
        field_chk("overflow_seen", overflow_seen, e.ovf);
      end
    end
  end

  function automatic int vlimit();
    return (np_sh > NV) ? NV : int'(np_sh);
  endfunction

  // random vertex index up to hi
  function automatic logic [IDX_W-1:0] rnd_idx(input int hi);
    return IDX_W'($urandom_range(0, hi));
  endfunction

  // sorted, duplicate-free insert into one neighbor set
  function automatic void set_add(input int v, input logic [IDX_W-1:0] x);
    int n, i;
    n = deg_sh[v];
    i = 0;
    while (i < n && nbr_sh[v][i] < x) i++;
    if (i < n && nbr_sh[v][i] == x) return;
    if (n >= ND) begin
      ovf_sh = 1'b1;
      return;
    end
    for (int k = n; k > i; k--) nbr_sh[v][k] = nbr_sh[v][k-1];
    nbr_sh[v][i] = x;
    deg_sh[v] = 5'(n + 1);
  endfunction

  // advance the shadow state for one request; queue results when keep is set
  function automatic void predict_csr(input logic [1:0] act, input logic [IDX_W-1:0] a,
                                      input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c,
                                      input bit keep);
    int lim, n;
    logic [IDX_W-1:0] cv;
    csr_word_t w;
    lim = vlimit();
    case (act)
      mcsr_pkg::ACT_CLEAR: begin
        foreach (deg_sh[i]) deg_sh[i] = '0;
        cursor_sh = '0;
        offset_sh = '0;
      end
      mcsr_pkg::ACT_ADD: begin
        if (a < lim && b < lim && c < lim) begin
          set_add(a, b); set_add(a, c);
          set_add(b, a); set_add(b, c);
          set_add(c, a); set_add(c, b);
        end
      end
      mcsr_pkg::ACT_EMIT: begin
        w.off = offset_sh;
        w.ovf = ovf_sh;
        w.nb = '0;
        w.nb_ok = 1'b0;
        w.last = 1'b1;
        if (cursor_sh >= lim) begin
          w.vtx = NP_W'(lim);
          w.eot = 1'b1;
          if (keep) pending_words.push_back(w);
        end else begin
          cv = IDX_W'(cursor_sh);
          n = deg_sh[cv];
          w.vtx = cursor_sh;
          w.eot = 1'b0;
          if (n == 0 && keep) pending_words.push_back(w);
          for (int k = 0; k < n; k++) begin
            w.nb = nbr_sh[cv][k];
            w.nb_ok = 1'b1;
            w.last = (k + 1 == n);
            if (keep) pending_words.push_back(w);
          end
          offset_sh = OFF_W'(offset_sh + n);
          cursor_sh = NP_W'(cursor_sh + 1);
        end
      end
      default: ;
    endcase
  endfunction

  // one request; bursts of back-to-back requests separated by random gaps
  task automatic send_req(input logic [1:0] act, input logic [IDX_W-1:0] a,
                          input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c,
                          input bit lit, input csr_word_t w);
    start <= 1'b1;
    action <= act;
    vertex_a <= a;
    vertex_b <= b;
    vertex_c <= c;
    do @(posedge clk); while (busy);
    predict_csr(act, a, b, c, !lit);
    if (lit) pending_words.push_back(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // wait until the block is idle, then write the vertex count
  task automatic write_np(input logic [NP_W-1:0] v);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    np_sh = v;
  endtask

  function automatic vec_t row(input bit s, input int np, input logic [1:0] act,
                               input int a, input int b, input int c);
    vec_t r;
    r.set_np = s; r.np = NP_W'(np); r.act = act;
    r.a = IDX_W'(a); r.b = IDX_W'(b); r.c = IDX_W'(c);
    r.lit = 1'b0;
    r.w = '{default: '0};
    return r;
  endfunction

  function automatic vec_t lit_row(input bit s, input int np, input logic [1:0] act,
                                   input int vtx, input bit eot, input bit ovf);
    vec_t r;
    r = row(s, np, act, 0, 0, 0);
    r.lit = 1'b1;
    r.w = '{vtx: NP_W'(vtx), off: '0, nb: '0, nb_ok: 1'b0, last: 1'b1, eot: eot, ovf: ovf};
    return r;
  endfunction

  // stimulus
  initial begin
    vec_t dir_tbl[$];
    csr_word_t none;
    int lim, pick, items;
    logic [NP_W-1:0] np_list[8] = '{3, 5, 8, 16, 40, 1024, 2047, 700};

    none = '{default: '0};
    rst = 1'b1; start = 1'b0; action = '0;
    vertex_a = '0; vertex_b = '0; vertex_c = '0;
    cfg_we = 1'b0; cfg_wdata = '0;
    np_sh = '0; cursor_sh = '0; offset_sh = '0; ovf_sh = 1'b0;
    foreach (deg_sh[i]) deg_sh[i] = '0;

    // directed: empty table, small mesh, degenerate, invalid, clear, overflow, extremes
    dir_tbl.push_back(lit_row(0, 0, mcsr_pkg::ACT_EMIT, 0, 1, 0));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_ADD, 0, 0, 0));
    dir_tbl.push_back(lit_row(0, 0, mcsr_pkg::ACT_EMIT, 0, 1, 0));
    dir_tbl.push_back(row(1, 4, mcsr_pkg::ACT_ADD, 0, 1, 2));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_ADD, 2, 1, 3));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_ADD, 3, 3, 3));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_ADD, 0, 1, 4));
    for (int i = 0; i < 5; i++) dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_EMIT, 0, 0, 0));
    dir_tbl.push_back(row(0, 0, ACT_NOP, 1023, 1023, 1023));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_CLEAR, 0, 0, 0));
    dir_tbl.push_back(lit_row(0, 0, mcsr_pkg::ACT_EMIT, 0, 0, 0));
    for (int k = 0; k < 9; k++)
      dir_tbl.push_back(row(k == 0, 1024, mcsr_pkg::ACT_ADD, 0, 2*k+1, 2*k+2));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_ADD, 1023, 1023, 1022));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_EMIT, 0, 0, 0));
    dir_tbl.push_back(row(0, 0, mcsr_pkg::ACT_EMIT, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].set_np) write_np(dir_tbl[i].np);
      send_req(dir_tbl[i].act, dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].c,
               dir_tbl[i].lit, dir_tbl[i].w);
    end

    // random phases, each with its own vertex count
    items = 0;
    while (items < 280) begin
      write_np(np_list[$urandom_range(0, 7)]);
      lim = vlimit();
      if ($urandom_range(0, 1)) begin
        send_req(mcsr_pkg::ACT_CLEAR, rnd_idx(1023), rnd_idx(1023), rnd_idx(1023), 0, none);
        items++;
      end
      repeat ($urandom_range(25, 50)) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)
          send_req(mcsr_pkg::ACT_CLEAR, rnd_idx(1023), rnd_idx(1023), rnd_idx(1023),
                   0, none);
        else if (pick < 4)
          send_req(ACT_NOP, rnd_idx(1023), rnd_idx(1023), rnd_idx(1023), 0, none);
        else if (pick < 12)
          send_req(mcsr_pkg::ACT_ADD, rnd_idx(1023), rnd_idx(1023), rnd_idx(1023),
                   0, none);
        else if (pick < 60)
          send_req(mcsr_pkg::ACT_ADD, rnd_idx(lim-1), rnd_idx(lim-1), rnd_idx(lim-1),
                   0, none);
        else
          send_req(mcsr_pkg::ACT_EMIT, rnd_idx(1023), rnd_idx(1023), rnd_idx(1023),
                   0, none);
        items++;
      end
    end

    // drain
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
